>>> rtl/udsdid_pkg.sv
`default_nettype none

package udsdid_pkg;

	// fixed-point format of scale_factor, engineering_bias and the result
	localparam int FRACTION_BITS = 24;

	// configuration port geometry: eight registers, 64-bit data, 8-byte stride
	localparam int NUM_REGS   = 8;
	localparam int DATA_W     = 64;
	localparam int REG_STRIDE = 8;
	localparam int ADDR_W     = $clog2(NUM_REGS * REG_STRIDE);
	localparam int IDX_LSB    = $clog2(REG_STRIDE);

	localparam logic [7:0] POSITIVE_REPLY   = 8'h62;
	localparam logic [3:0] MIN_FRAME_LENGTH = 4'd4;
	localparam logic [3:0] MAX_FRAME_LENGTH = 4'd8;

	// 1.0 in the scale format
	localparam logic [31:0] SCALE_RESET = 32'(64'(1) << FRACTION_BITS);

	// widths along the datapath
	localparam int RAW_W  = 32;
	localparam int ADJ_W  = RAW_W + 2;
	localparam int PROD_W = ADJ_W + 32;
	localparam int SUM_W  = PROD_W + 1;

	typedef enum logic [2:0] {
		REG_DIAG     = 3'd0,
		REG_FRAME_ID = 3'd1,
		REG_DID      = 3'd2,
		REG_FLEN     = 3'd3,
		REG_FOFS     = 3'd4,
		REG_RAW_BIAS = 3'd5,
		REG_SCALE    = 3'd6,
		REG_ENG_BIAS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        definition_is_diagnostic;
		logic [28:0] reply_frame_id;
		logic [15:0] data_identifier;
		logic [2:0]  field_length;
		logic [2:0]  field_offset;
		logic [31:0] raw_bias;
		logic [31:0] scale_factor;
		logic [39:0] engineering_bias;
	} cfg_t;

	// one received frame; byte 0 is not carried
	typedef struct packed {
		logic [28:0]      ident;
		logic [3:0]       length;
		logic [7:1][7:0]  data;
	} frame_t;

	// outcome of the frame checks plus the biased raw field
	typedef struct packed {
		logic             ok;
		logic [ADJ_W-1:0] adj;
	} check_t;

endpackage

`default_nettype wire

>>> rtl/uds_did_response_decoder.sv
// pipeline: a frame taken by start is registered in s1, checked into s2, multiplied
//   into s3, biased and saturated into s4, where done shows it (four register stages)
// throughput: one frame per clock, busy never rises; the slowest path is the
//   34 x 32 signed multiply between the check stage and the bias stage
// reset: arst_n clears the pipeline valids and loads the registers with their
//   defaults (scale 1.0); the receiver cannot stall, each result shows once
`default_nettype none

module uds_did_response_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,

	// config port
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [udsdid_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [udsdid_pkg::DATA_W-1:0]  pwdata,
	output logic      [udsdid_pkg::DATA_W-1:0]  prdata,
	output logic                                pready,

	// frame in
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [28:0]                    frame_ident,
	input  wire logic [3:0]                     frame_length,
	input  wire logic [7:0]                     data_byte_1,
	input  wire logic [7:0]                     data_byte_2,
	input  wire logic [7:0]                     data_byte_3,
	input  wire logic [7:0]                     data_byte_4,
	input  wire logic [7:0]                     data_byte_5,
	input  wire logic [7:0]                     data_byte_6,
	input  wire logic [7:0]                     data_byte_7,

	// result out
	output logic                                done,
	output logic                                accepted,
	output logic signed [63:0]                  signal_value
);

	udsdid_pkg::cfg_t    cfg;
	udsdid_pkg::frame_t  frame_s1;
	udsdid_pkg::check_t  chk_s2;
	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s4;
	logic                ok_s4;
	logic [63:0]         value_s4;

	// every stage moves each cycle, so a new item can enter every clock
	assign busy = 1'b0;

	udsdid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		frame_s1.ident   <= frame_ident;
		frame_s1.length  <= frame_length;
		frame_s1.data[1] <= data_byte_1;
		frame_s1.data[2] <= data_byte_2;
		frame_s1.data[3] <= data_byte_3;
		frame_s1.data[4] <= data_byte_4;
		frame_s1.data[5] <= data_byte_5;
		frame_s1.data[6] <= data_byte_6;
		frame_s1.data[7] <= data_byte_7;
	end

	// header checks, field gather and raw bias
	udsdid_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.frame_s1 (frame_s1),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.chk_s2   (chk_s2)
	);

	// scale multiply, engineering bias and saturation
	udsdid_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.chk_s2   (chk_s2),
		.cfg      (cfg),
		.valid_s4 (valid_s4),
		.ok_s4    (ok_s4),
		.value_s4 (value_s4)
	);

	assign done         = valid_s4;
	assign accepted     = ok_s4;
	assign signal_value = $signed(value_s4);

endmodule

`default_nettype wire

>>> rtl/udsdid_regs.sv
`default_nettype none

module udsdid_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [udsdid_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [udsdid_pkg::DATA_W-1:0]  pwdata,
	output logic      [udsdid_pkg::DATA_W-1:0]  prdata,
	output logic                                pready,
	output udsdid_pkg::cfg_t                    cfg
);

	udsdid_pkg::cfg_t     cfg_q;
	udsdid_pkg::reg_idx_t idx;
	logic                 wr_en;

	assign pready = 1'b1;
	assign idx    = udsdid_pkg::reg_idx_t'(paddr[udsdid_pkg::ADDR_W-1:udsdid_pkg::IDX_LSB]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.definition_is_diagnostic <= 1'b0;
			cfg_q.reply_frame_id           <= '0;
			cfg_q.data_identifier          <= '0;
			cfg_q.field_length             <= '0;
			cfg_q.field_offset             <= '0;
			cfg_q.raw_bias                 <= '0;
			cfg_q.scale_factor             <= udsdid_pkg::SCALE_RESET;
			cfg_q.engineering_bias         <= '0;
		end else if (wr_en) begin
			case (idx)
				udsdid_pkg::REG_DIAG:     cfg_q.definition_is_diagnostic <= pwdata[0];
				udsdid_pkg::REG_FRAME_ID: cfg_q.reply_frame_id           <= pwdata[28:0];
				udsdid_pkg::REG_DID:      cfg_q.data_identifier          <= pwdata[15:0];
				udsdid_pkg::REG_FLEN:     cfg_q.field_length             <= pwdata[2:0];
				udsdid_pkg::REG_FOFS:     cfg_q.field_offset             <= pwdata[2:0];
				udsdid_pkg::REG_RAW_BIAS: cfg_q.raw_bias                 <= pwdata[31:0];
				udsdid_pkg::REG_SCALE:    cfg_q.scale_factor             <= pwdata[31:0];
				udsdid_pkg::REG_ENG_BIAS: cfg_q.engineering_bias         <= pwdata[39:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			udsdid_pkg::REG_DIAG:     prdata = 64'(cfg_q.definition_is_diagnostic);
			udsdid_pkg::REG_FRAME_ID: prdata = 64'(cfg_q.reply_frame_id);
			udsdid_pkg::REG_DID:      prdata = 64'(cfg_q.data_identifier);
			udsdid_pkg::REG_FLEN:     prdata = 64'(cfg_q.field_length);
			udsdid_pkg::REG_FOFS:     prdata = 64'(cfg_q.field_offset);
			udsdid_pkg::REG_RAW_BIAS: prdata = 64'(cfg_q.raw_bias);
			udsdid_pkg::REG_SCALE:    prdata = 64'(cfg_q.scale_factor);
			udsdid_pkg::REG_ENG_BIAS: prdata = 64'(cfg_q.engineering_bias);
			default:                  prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/udsdid_check.sv
`default_nettype none

module udsdid_check (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s1,
	input  wire udsdid_pkg::frame_t  frame_s1,
	input  wire udsdid_pkg::cfg_t    cfg,
	output logic                     valid_s2,
	output udsdid_pkg::check_t       chk_s2
);

	logic [7:0][7:0]                   bytes_c;
	logic [3:0][7:0]                   sel_c;
	logic [3:0]                        len_c;
	logic [3:0]                        start_c;
	logic [4:0]                        end_c;
	logic [udsdid_pkg::RAW_W-1:0]      raw_c;
	logic                              ok_c;
	udsdid_pkg::check_t                chk_c;

	always_comb begin
		bytes_c[0] = 8'h00;
		for (int i = 1; i < 8; i++) begin
			bytes_c[i] = frame_s1.data[i];
		end
		// gather window starts at byte 4 plus the offset, wraps modulo eight bytes
		for (int k = 0; k < 4; k++) begin
			sel_c[k] = bytes_c[cfg.field_offset + udsdid_pkg::MIN_FRAME_LENGTH[2:0] + 3'(k)];
		end
	end

	always_comb begin
		len_c   = (frame_s1.length > udsdid_pkg::MAX_FRAME_LENGTH) ?
			udsdid_pkg::MAX_FRAME_LENGTH : frame_s1.length;
		start_c = udsdid_pkg::MIN_FRAME_LENGTH + {1'b0, cfg.field_offset};
		end_c   = {1'b0, start_c} + {2'b00, cfg.field_length};

		ok_c = cfg.definition_is_diagnostic
			&& (frame_s1.ident == cfg.reply_frame_id)
			&& (len_c >= udsdid_pkg::MIN_FRAME_LENGTH)
			&& (frame_s1.data[1] == udsdid_pkg::POSITIVE_REPLY)
			&& (frame_s1.data[2] == cfg.data_identifier[15:8])
			&& (frame_s1.data[3] == cfg.data_identifier[7:0])
			&& (cfg.field_length inside {[3'd1:3'd4]})
			&& (end_c <= {1'b0, len_c});

		// big-endian field
		case (cfg.field_length)
			3'd1:    raw_c = {24'h0, sel_c[0]};
			3'd2:    raw_c = {16'h0, sel_c[0], sel_c[1]};
			3'd3:    raw_c = {8'h0, sel_c[0], sel_c[1], sel_c[2]};
			3'd4:    raw_c = {sel_c[0], sel_c[1], sel_c[2], sel_c[3]};
			default: raw_c = '0;
		endcase

		chk_c.ok  = ok_c;
		chk_c.adj = ok_c ? ({2'b00, raw_c} + {{2{cfg.raw_bias[31]}}, cfg.raw_bias}) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		chk_s2 <= chk_c;
	end

endmodule

`default_nettype wire

>>> rtl/udsdid_mac.sv
`default_nettype none

module udsdid_mac (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                valid_s2,
	input  wire udsdid_pkg::check_t  chk_s2,
	input  wire udsdid_pkg::cfg_t    cfg,
	output logic                     valid_s4,
	output logic                     ok_s4,
	output logic [63:0]              value_s4
);

	logic                                  valid_s3;
	logic                                  ok_s3;
	logic signed [udsdid_pkg::PROD_W-1:0]  prod_c;
	logic signed [udsdid_pkg::PROD_W-1:0]  prod_s3;
	logic signed [udsdid_pkg::SUM_W-1:0]   sum_c;
	logic [63:0]                           sat_c;
	logic                                  in_range_c;

	// signed multiply, product is exact in PROD_W bits
	assign prod_c = $signed(chk_s2.adj) * $signed(cfg.scale_factor);

	always_comb begin
		sum_c = {prod_s3[udsdid_pkg::PROD_W-1], prod_s3}
			+ {{(udsdid_pkg::SUM_W-40){cfg.engineering_bias[39]}}, cfg.engineering_bias};
		// fits when all bits above bit 63 repeat the sign
		in_range_c = (sum_c[udsdid_pkg::SUM_W-1:63] == '0)
			|| (sum_c[udsdid_pkg::SUM_W-1:63] == '1);
		if (in_range_c) begin
			sat_c = sum_c[63:0];
		end else if (sum_c[udsdid_pkg::SUM_W-1]) begin
			sat_c = 64'h8000_0000_0000_0000;
		end else begin
			sat_c = 64'h7FFF_FFFF_FFFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			ok_s4    <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			ok_s4    <= valid_s3 & ok_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s3    <= chk_s2.ok;
		prod_s3  <= prod_c;
		value_s4 <= ok_s3 ? sat_c : 64'h0;
	end

endmodule

`default_nettype wire

>>> rtl/udsdid_checker.sv
`default_nettype none

module udsdid_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire logic               accepted,
	input wire logic signed [63:0] signal_value,
	input wire logic               pready
);

	// every item taken gives exactly one result, checked in both directions
	a_latency_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("result missing for an accepted item");

	a_latency_back: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 4))
		else $error("result without an accepted item");

	// a rejected frame reports zero
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !accepted |-> signal_value == 64'sd0)
		else $error("rejected frame carries a value");

	// accepted flag only shows with a result
	a_accept_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		accepted |-> done)
		else $error("accepted without done");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && pready)
		else $error("busy or pready dropped");

endmodule

bind uds_did_response_decoder udsdid_checker u_checker (.*);

`default_nettype wire

>>> verif/uds_did_response_decoder_tb.sv
`default_nettype none

module uds_did_response_decoder_tb;
	import udsdid_pkg::*;

	// cycles without any item or result moving before the run is called hung
	localparam int QUIET_LIMIT = 2000;
	// random part: phases of fresh register settings, items per phase
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 100;

	localparam logic signed [127:0] VALUE_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [127:0] VALUE_MIN = ~VALUE_MAX;

	// ways a well-formed reply gets broken
	typedef enum int {
		CORRUPT_IDENT,
		CORRUPT_LENGTH,
		CORRUPT_REPLY,
		CORRUPT_DID_HI,
		CORRUPT_DID_LO
	} corrupt_t;

	typedef struct packed {
		logic        accepted;
		logic [63:0] value;
	} result_t;

	// one line of the directed table: a register write or a frame
	typedef struct {
		bit          is_write;
		reg_idx_t    reg_sel;
		logic [63:0] wr_value;
		frame_t      frame;
		bit          typed;
		result_t     typed_res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	logic        start = 1'b0;
	logic        busy;
	logic [28:0] frame_ident = '0;
	logic [3:0]  frame_length = '0;
	logic [7:0]  data_byte_1 = '0;
	logic [7:0]  data_byte_2 = '0;
	logic [7:0]  data_byte_3 = '0;
	logic [7:0]  data_byte_4 = '0;
	logic [7:0]  data_byte_5 = '0;
	logic [7:0]  data_byte_6 = '0;
	logic [7:0]  data_byte_7 = '0;

	logic               done;
	logic               accepted;
	logic signed [63:0] signal_value;

	// shadow of the signal definition held in the block
	cfg_t definition = '{
		definition_is_diagnostic: 1'b0,
		reply_frame_id: '0,
		data_identifier: '0,
		field_length: '0,
		field_offset: '0,
		raw_bias: '0,
		scale_factor: SCALE_RESET,
		engineering_bias: '0
	};

	result_t   pending_decodes[$];
	stim_row_t directed_rows[$];
	int        mismatch_count = 0;
	int        quiet_cycles = 0;

	uds_did_response_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.frame_ident(frame_ident),
		.frame_length(frame_length),
		.data_byte_1(data_byte_1),
		.data_byte_2(data_byte_2),
		.data_byte_3(data_byte_3),
		.data_byte_4(data_byte_4),
		.data_byte_5(data_byte_5),
		.data_byte_6(data_byte_6),
		.data_byte_7(data_byte_7),
		.done(done),
		.accepted(accepted),
		.signal_value(signal_value)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// decode of one frame against the current definition
	function automatic result_t predict_decode(input frame_t f);
		logic [7:0]          bytes [8];
		int unsigned         len;
		int unsigned         pos;
		logic [31:0]         raw;
		logic signed [127:0] adj;
		logic signed [127:0] scl;
		logic signed [127:0] bias;
		logic signed [127:0] sum;
		bit                  ok;
		result_t             r;
		bytes[0] = '0;
		for (int i = 1; i < 8; i++) begin
			bytes[i] = f.data[i];
		end
		// a frame never holds more than eight data bytes
		len = (f.length > MAX_FRAME_LENGTH) ? 8 : f.length;
		pos = MIN_FRAME_LENGTH + definition.field_offset;
		ok = definition.definition_is_diagnostic
			&& f.ident == definition.reply_frame_id
			&& len >= MIN_FRAME_LENGTH
			&& bytes[1] == POSITIVE_REPLY
			&& bytes[2] == definition.data_identifier[15:8]
			&& bytes[3] == definition.data_identifier[7:0]
			&& definition.field_length >= 1 && definition.field_length <= 4
			&& pos + definition.field_length <= len;
		r.accepted = ok;
		r.value = '0;
		if (!ok)
			return r;
		raw = '0;
		for (int i = 0; i < definition.field_length; i++) begin
			raw = (raw << 8) | bytes[(pos + i) & 7];
		end
		// exact arithmetic in a wide signed word, then clamp to 64 bits
		adj = $signed({96'b0, raw})
			+ $signed({{96{definition.raw_bias[31]}}, definition.raw_bias});
		scl = $signed({{96{definition.scale_factor[31]}}, definition.scale_factor});
		bias = $signed({{88{definition.engineering_bias[39]}}, definition.engineering_bias});
		sum = adj * scl + bias;
		if (sum > VALUE_MAX)
			r.value = VALUE_MAX[63:0];
		else if (sum < VALUE_MIN)
			r.value = VALUE_MIN[63:0];
		else
			r.value = sum[63:0];
		return r;
	endfunction

	function automatic logic [7:0] random_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] random_word32();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3: return 32'hFFFF_FFFF;
			4: return 32'($urandom_range(0, 511)) - 32'd256;
			default: return $urandom;
		endcase
	endfunction

	// mostly replies that pass every check, some broken, some plain noise
	function automatic frame_t random_frame();
		frame_t      f;
		int unsigned need;
		corrupt_t    how;
		for (int i = 1; i < 8; i++) begin
			f.data[i] = random_byte();
		end
		f.ident = 29'($urandom);
		f.length = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 3) != 0) begin
			f.ident = definition.reply_frame_id;
			f.data[1] = POSITIVE_REPLY;
			f.data[2] = definition.data_identifier[15:8];
			f.data[3] = definition.data_identifier[7:0];
			need = MIN_FRAME_LENGTH + definition.field_offset + definition.field_length;
			if (need <= 8)
				f.length = 4'($urandom_range(need, 8));
			else
				f.length = 4'($urandom_range(4, 8));
			// oversized length counts as eight
			if ($urandom_range(0, 15) == 0)
				f.length = 4'($urandom_range(9, 15));
			if ($urandom_range(0, 4) == 0) begin
				how = corrupt_t'($urandom_range(0, 4));
				case (how)
					CORRUPT_IDENT: f.ident = f.ident ^ (29'd1 << $urandom_range(0, 28));
					CORRUPT_LENGTH: f.length = 4'($urandom_range(0, 15));
					CORRUPT_REPLY: f.data[1] = random_byte();
					CORRUPT_DID_HI: f.data[2] = random_byte();
					CORRUPT_DID_LO: f.data[3] = random_byte();
				endcase
			end
		end
		return f;
	endfunction

	function automatic void add_write(input reg_idx_t idx, input logic [63:0] value);
		stim_row_t row;
		row.is_write = 1'b1;
		row.reg_sel = idx;
		row.wr_value = value;
		row.frame = '0;
		row.typed = 1'b0;
		row.typed_res = '0;
		directed_rows.push_back(row);
	endfunction

	// bytes_1_to_7 lists data byte 1 in its top byte down to byte 7
	function automatic void add_frame(input logic [28:0] ident, input logic [3:0] len,
			input logic [55:0] bytes_1_to_7, input bit typed = 1'b0,
			input logic acc = 1'b0, input logic [63:0] val = '0);
		stim_row_t row;
		row.is_write = 1'b0;
		row.reg_sel = REG_DIAG;
		row.wr_value = '0;
		row.frame.ident = ident;
		row.frame.length = len;
		for (int i = 1; i < 8; i++) begin
			row.frame.data[i] = bytes_1_to_7[(7 - i) * 8 +: 8];
		end
		row.typed = typed;
		row.typed_res.accepted = acc;
		row.typed_res.value = val;
		directed_rows.push_back(row);
	endfunction

	// apb write: setup cycle, access cycle, shadow follows the register
	task automatic write_register(input reg_idx_t idx, input logic [63:0] value);
		logic [63:0] masked;
		masked = '0;
		case (idx)
			REG_DIAG: begin
				masked[0] = value[0];
				definition.definition_is_diagnostic = value[0];
			end
			REG_FRAME_ID: begin
				masked[28:0] = value[28:0];
				definition.reply_frame_id = value[28:0];
			end
			REG_DID: begin
				masked[15:0] = value[15:0];
				definition.data_identifier = value[15:0];
			end
			REG_FLEN: begin
				masked[2:0] = value[2:0];
				definition.field_length = value[2:0];
			end
			REG_FOFS: begin
				masked[2:0] = value[2:0];
				definition.field_offset = value[2:0];
			end
			REG_RAW_BIAS: begin
				masked[31:0] = value[31:0];
				definition.raw_bias = value[31:0];
			end
			REG_SCALE: begin
				masked[31:0] = value[31:0];
				definition.scale_factor = value[31:0];
			end
			REG_ENG_BIAS: begin
				masked[39:0] = value[39:0];
				definition.engineering_bias = value[39:0];
			end
		endcase
		// the wait before the setup phase keeps back-to-back writes apart
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(idx) * REG_STRIDE);
		pwdata <= masked;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drop start and hold until every decode in flight has come back
	task automatic drain_decodes();
		start <= 1'b0;
		do @(posedge clk); while (pending_decodes.size() != 0);
	endtask

	// offer one frame after gap idle cycles, record what it must give
	task automatic send_frame(input frame_t f, input int gap, input bit typed,
			input result_t typed_res);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		frame_ident <= f.ident;
		frame_length <= f.length;
		data_byte_1 <= f.data[1];
		data_byte_2 <= f.data[2];
		data_byte_3 <= f.data[3];
		data_byte_4 <= f.data[4];
		data_byte_5 <= f.data[5];
		data_byte_6 <= f.data[6];
		data_byte_7 <= f.data[7];
		do @(posedge clk); while (busy);
		pending_decodes.push_back(typed ? typed_res : predict_decode(f));
	endtask

	// fresh definition for one random phase, extremes mixed in
	task automatic write_random_definition(input bit diagnostic);
		logic [2:0]  flen;
		logic [39:0] eng;
		flen = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
		case ($urandom_range(0, 4))
			0: eng = 40'h7F_FFFF_FFFF;
			1: eng = 40'h80_0000_0000;
			2: eng = '0;
			default: eng = {8'($urandom), 32'($urandom)};
		endcase
		write_register(REG_DIAG, 64'(diagnostic));
		case ($urandom_range(0, 3))
			0: write_register(REG_FRAME_ID, 64'($urandom_range(0, 11'h7FF)));
			1: write_register(REG_FRAME_ID, 64'h1FFF_FFFF);
			default: write_register(REG_FRAME_ID, 64'(29'($urandom)));
		endcase
		write_register(REG_DID, 64'(16'($urandom)));
		write_register(REG_FLEN, 64'(flen));
		if (flen >= 1 && flen <= 4 && $urandom_range(0, 7) != 0)
			write_register(REG_FOFS, 64'($urandom_range(0, 4 - flen)));
		else
			write_register(REG_FOFS, 64'($urandom_range(0, 7)));
		write_register(REG_RAW_BIAS, 64'(random_word32()));
		if ($urandom_range(0, 2) == 0)
			write_register(REG_SCALE, 64'(SCALE_RESET));
		else
			write_register(REG_SCALE, 64'(random_word32()));
		write_register(REG_ENG_BIAS, 64'(eng));
	endtask

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch: %s", msg);
	endtask

	// each done cycle carries one result; compare with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_decodes.size() == 0) begin
				note_mismatch($sformatf("result with none expected: accepted %0b value %h",
					accepted, signal_value));
			end else begin
				want = pending_decodes.pop_front();
				if (accepted !== want.accepted)
					note_mismatch($sformatf("accepted exp %0b got %0b", want.accepted,
						accepted));
				if (signal_value !== want.value)
					note_mismatch($sformatf("signal_value exp %h got %h", want.value,
						signal_value));
			end
		end
	end

	// watchdog: any item or result moving counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("uds_did_response_decoder_tb failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		bit burst;
		// reset definition: not diagnostic and no field length, so a matching reply is still refused
		add_frame(29'h0, 4'd8, 56'h62_0000_0000_0000, 1'b1, 1'b0, 64'h0);
		// all-ones identifiers, four-byte field at the first payload byte
		add_write(REG_DIAG, 64'd1);
		add_write(REG_FRAME_ID, 64'h1FFF_FFFF);
		add_write(REG_DID, 64'hFFFF);
		add_write(REG_FLEN, 64'd4);
		add_write(REG_FOFS, 64'd0);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b1,
			64'h00FF_FFFF_FF00_0000);
		// each check failing on its own
		add_frame(29'h1FFF_FFFE, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		add_frame(29'h1FFF_FFFF, 4'd3, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h7F_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FEFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFE_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		// field runs one byte past the frame end
		add_frame(29'h1FFF_FFFF, 4'd7, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		// length above eight counts as eight
		add_frame(29'h1FFF_FFFF, 4'd15, 56'h62_FFFF_1234_5678);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_0000_0000, 1'b1, 1'b1, 64'h0);
		// field lengths outside one to four
		add_write(REG_FLEN, 64'd0);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		add_write(REG_FLEN, 64'd7);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		add_write(REG_FLEN, 64'd5);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		// one byte in the last slot, then one past the end
		add_write(REG_FLEN, 64'd1);
		add_write(REG_FOFS, 64'd3);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_0000_00A5);
		add_frame(29'h1FFF_FFFF, 4'd7, 56'h62_FFFF_0000_00A5, 1'b1, 1'b0, 64'h0);
		add_write(REG_FOFS, 64'd7);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0);
		// largest magnitudes: clamp high, then clamp low
		add_write(REG_FOFS, 64'd0);
		add_write(REG_FLEN, 64'd4);
		add_write(REG_RAW_BIAS, 64'h7FFF_FFFF);
		add_write(REG_SCALE, 64'h7FFF_FFFF);
		add_write(REG_ENG_BIAS, 64'h7F_FFFF_FFFF);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b1,
			64'h7FFF_FFFF_FFFF_FFFF);
		add_write(REG_SCALE, 64'h8000_0000);
		add_write(REG_ENG_BIAS, 64'h80_0000_0000);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF, 1'b1, 1'b1,
			64'h8000_0000_0000_0000);
		// most negative bias times most negative scale
		add_write(REG_RAW_BIAS, 64'h8000_0000);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_0000_0000);
		add_frame(29'h1FFF_FFFF, 4'd8, 56'h62_FFFF_FFFF_FFFF);
		// short identifier, negative scale of smallest magnitude
		add_write(REG_FRAME_ID, 64'h155);
		add_write(REG_DID, 64'h1234);
		add_write(REG_RAW_BIAS, 64'h0);
		add_write(REG_SCALE, 64'hFFFF_FFFF);
		add_write(REG_ENG_BIAS, 64'h1_2345);
		add_frame(29'h155, 4'd8, 56'h62_1234_8000_0000);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; writes only once the pipe is empty
		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_write) begin
				if (pending_decodes.size() != 0)
					drain_decodes();
				else
					start <= 1'b0;
				write_register(directed_rows[i].reg_sel, directed_rows[i].wr_value);
			end else begin
				send_frame(directed_rows[i].frame, $urandom_range(0, 17),
					directed_rows[i].typed, directed_rows[i].typed_res);
			end
		end

		// random phases; one phase runs with the definition switched off
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_decodes();
			write_random_definition(p != 3);
			// every third phase streams items back to back
			burst = (p % 3 == 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// now and then let the pipe run dry mid-phase
				if (n > 0 && $urandom_range(0, 40) == 0)
					drain_decodes();
				send_frame(random_frame(), burst ? 0 : $urandom_range(0, 17), 1'b0, '0);
			end
		end

		drain_decodes();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("uds_did_response_decoder_tb passed");
		else
			$display("uds_did_response_decoder_tb failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/udsdid_pkg.sv
rtl/udsdid_regs.sv
rtl/udsdid_check.sv
rtl/udsdid_mac.sv
rtl/uds_did_response_decoder.sv
rtl/udsdid_checker.sv
verif/uds_did_response_decoder_tb.sv
